// ===== rtl/tlge_pkg.sv =====
`timescale 1ns / 1ps

package tlge_pkg;

    localparam int ROWS    = 64;
    localparam int COLS    = 64;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLS);
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int GEN_W   = 32;
    localparam int COUNT_W = 13;
    localparam int SUM_W   = 4;

    localparam logic [SUM_W-1:0]   BIRTH_SUM = SUM_W'(3);
    localparam logic [SUM_W-1:0]   KEEP_SUM  = SUM_W'(4);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ADVANCE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef struct packed {
        logic clr;
        logic en;
    } t_cell_ctl;

endpackage

// ===== rtl/tlge_ram.sv =====
`timescale 1ns / 1ps

module tlge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tlge_cell_unit.sv =====
`timescale 1ns / 1ps

module tlge_cell_unit
    import tlge_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [2:0]         i_top,
    input  logic [2:0]         i_mid,
    input  logic [2:0]         i_bot,
    output logic               o_next,
    output logic [COUNT_W-1:0] o_live,
    output logic [COUNT_W-1:0] o_born,
    output logic [COUNT_W-1:0] o_died
);

    logic [SUM_W-1:0]   w_sum;
    logic               w_old;
    logic               w_next;
    logic [COUNT_W-1:0] r_live;
    logic [COUNT_W-1:0] r_born;
    logic [COUNT_W-1:0] r_died;

    assign w_sum = SUM_W'(i_top[0]) + SUM_W'(i_top[1]) + SUM_W'(i_top[2])
                 + SUM_W'(i_mid[0]) + SUM_W'(i_mid[1]) + SUM_W'(i_mid[2])
                 + SUM_W'(i_bot[0]) + SUM_W'(i_bot[1]) + SUM_W'(i_bot[2]);
    assign w_old  = i_mid[1];
    assign w_next = (w_sum == BIRTH_SUM) || (w_old && (w_sum == KEEP_SUM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_live <= '0;
            r_born <= '0;
            r_died <= '0;
        end else if (i_ctl.en) begin
            if (w_next && (r_live != COUNT_MAX)) begin
                r_live <= r_live + COUNT_W'(1);
            end
            if (w_next && !w_old && (r_born != COUNT_MAX)) begin
                r_born <= r_born + COUNT_W'(1);
            end
            if (!w_next && w_old && (r_died != COUNT_MAX)) begin
                r_died <= r_died + COUNT_W'(1);
            end
        end
    end

    assign o_next = w_next;
    assign o_live = r_live;
    assign o_born = r_born;
    assign o_died = r_died;

endmodule

// ===== rtl/toroidal_life_grid_engine.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_stall   i_op, i_row, i_col, i_cell_in
// result    out        o_valid / i_stall   o_cell_out, o_generation, o_live_count,
//                                          o_born_count, o_died_count
// An advance loads three rows in S_L0 to S_L3, then takes one cell per cycle through the
// shared cell unit, with a write-back per grid row and a row fetch between grid rows.
// A write or a read passes S_ACC_RD, S_ACC_DO and S_DONE; a clear zeroes each memory row in S_CLR.
// After reset the grid memory is cleared row by row in S_INIT, during which o_stall is high.
// A finished word waits in the output register; the next item is taken meanwhile.

module toroidal_life_grid_engine
    import tlge_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [IDX_W-1:0]   i_row,
    input  logic [IDX_W-1:0]   i_col,
    input  logic               i_cell_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_cell_out,
    output logic [GEN_W-1:0]   o_generation,
    output logic [COUNT_W-1:0] o_live_count,
    output logic [COUNT_W-1:0] o_born_count,
    output logic [COUNT_W-1:0] o_died_count
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ACC_RD,
        S_ACC_DO,
        S_CLR,
        S_L0,
        S_L1,
        S_L2,
        S_L3,
        S_CELL,
        S_WB,
        S_FETCH,
        S_DONE
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_op                r_op;
    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_col;
    logic               r_cell_in;
    logic               r_ok;
    logic               r_cell_res;
    logic [ROW_W-1:0]   r_rowc;
    logic [COL_W-1:0]   r_colc;
    logic [COLS-1:0]    r_top;
    logic [COLS-1:0]    r_mid;
    logic [COLS-1:0]    r_bot;
    logic [COLS-1:0]    r_save0;
    logic [COLS-1:0]    r_nrow;
    logic [GEN_W-1:0]   r_gen;
    logic [COUNT_W-1:0] r_last_live;
    logic [COUNT_W-1:0] r_last_born;
    logic [COUNT_W-1:0] r_last_died;
    logic               r_out_valid;
    logic               r_out_cell;
    logic [GEN_W-1:0]   r_out_gen;
    logic [COUNT_W-1:0] r_out_live;
    logic [COUNT_W-1:0] r_out_born;
    logic [COUNT_W-1:0] r_out_died;

    logic               w_accept;
    logic               w_out_free;
    logic [ROW_W-1:0]   w_addr_row;
    logic [COL_W-1:0]   w_col_idx;
    logic               w_we;
    logic [ROW_W-1:0]   w_waddr;
    logic [COLS-1:0]    w_wdata;
    logic [ROW_W-1:0]   w_raddr;
    logic [COLS-1:0]    w_rdata;
    logic [COLS-1:0]    w_mod;
    t_cell_ctl          w_ctl;
    logic               w_next;
    logic [COUNT_W-1:0] w_live;
    logic [COUNT_W-1:0] w_born;
    logic [COUNT_W-1:0] w_died;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_addr_row = ROW_W'(r_row);
    assign w_col_idx  = COL_W'(r_col);

    tlge_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_ctl.clr = (r_state == S_L0);
    assign w_ctl.en  = (r_state == S_CELL);

    tlge_cell_unit u_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_top   ({r_top[1], r_top[0], r_top[COLS-1]}),
        .i_mid   ({r_mid[1], r_mid[0], r_mid[COLS-1]}),
        .i_bot   ({r_bot[1], r_bot[0], r_bot[COLS-1]}),
        .o_next  (w_next),
        .o_live  (w_live),
        .o_born  (w_born),
        .o_died  (w_died)
    );

    always_comb begin
        w_mod            = w_rdata;
        w_mod[w_col_idx] = r_cell_in;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rowc;
        w_wdata = '0;
        w_raddr = '0;
        case (r_state)
            S_INIT, S_CLR: begin
                w_we = 1'b1;
            end
            S_ACC_RD: begin
                w_raddr = w_addr_row;
            end
            S_ACC_DO: begin
                w_we    = (r_op == OP_WRITE) && r_ok;
                w_waddr = w_addr_row;
                w_wdata = w_mod;
            end
            S_L0: begin
                w_raddr = ROW_W'(ROWS - 1);
            end
            S_L1: begin
                w_raddr = '0;
            end
            S_L2: begin
                w_raddr = ROW_W'(1);
            end
            S_WB: begin
                w_we    = 1'b1;
                w_wdata = r_nrow;
                w_raddr = r_rowc + ROW_W'(2);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_rowc == ROW_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_op))
                        OP_ADVANCE: n_state = S_L0;
                        OP_CLEAR:   n_state = S_CLR;
                        default:    n_state = S_ACC_RD;
                    endcase
                end
            end
            S_ACC_RD: n_state = S_ACC_DO;
            S_ACC_DO: n_state = S_DONE;
            S_CLR: begin
                if (r_rowc == ROW_W'(ROWS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_L0: n_state = S_L1;
            S_L1: n_state = S_L2;
            S_L2: n_state = S_L3;
            S_L3: n_state = S_CELL;
            S_CELL: begin
                if (r_colc == COL_W'(COLS - 1)) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (r_rowc == ROW_W'(ROWS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_CELL;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_rowc      <= '0;
            r_colc      <= '0;
            r_gen       <= '0;
            r_last_live <= '0;
            r_last_born <= '0;
            r_last_died <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT, S_CLR: begin
                    r_rowc <= r_rowc + ROW_W'(1);
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op       <= t_op'(i_op);
                        r_row      <= i_row;
                        r_col      <= i_col;
                        r_cell_in  <= i_cell_in;
                        r_ok       <= (int'(i_row) < ROWS) && (int'(i_col) < COLS);
                        r_cell_res <= 1'b0;
                        r_rowc     <= '0;
                    end
                end
                S_ACC_DO: begin
                    if (r_op == OP_READ) begin
                        r_cell_res <= r_ok && w_rdata[w_col_idx];
                    end
                end
                S_L1: begin
                    r_top <= w_rdata;
                end
                S_L2: begin
                    r_mid   <= w_rdata;
                    r_save0 <= w_rdata;
                end
                S_L3: begin
                    r_bot  <= w_rdata;
                    r_colc <= '0;
                end
                S_CELL: begin
                    r_top  <= {r_top[0], r_top[COLS-1:1]};
                    r_mid  <= {r_mid[0], r_mid[COLS-1:1]};
                    r_bot  <= {r_bot[0], r_bot[COLS-1:1]};
                    r_nrow <= {w_next, r_nrow[COLS-1:1]};
                    r_colc <= r_colc + COL_W'(1);
                end
                S_WB: begin
                    r_top <= r_mid;
                    r_mid <= r_bot;
                    if (r_rowc == ROW_W'(ROWS - 1)) begin
                        r_gen       <= r_gen + GEN_W'(1);
                        r_last_live <= w_live;
                        r_last_born <= w_born;
                        r_last_died <= w_died;
                    end
                end
                S_FETCH: begin
                    r_bot  <= (r_rowc == ROW_W'(ROWS - 2)) ? r_save0 : w_rdata;
                    r_rowc <= r_rowc + ROW_W'(1);
                    r_colc <= '0;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_cell <= r_cell_res;
                        r_out_gen  <= r_gen;
                        r_out_live <= r_last_live;
                        r_out_born <= r_last_born;
                        r_out_died <= r_last_died;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_cell_out   = r_out_cell;
    assign o_generation = r_out_gen;
    assign o_live_count = r_out_live;
    assign o_born_count = r_out_born;
    assign o_died_count = r_out_died;

`ifndef SYNTHESIS
    a_gen_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_gen)) |->
            ($past(r_state) == S_WB && r_gen == $past(r_gen) + GEN_W'(1)))
        else $error("generation count changed outside the end of an advance");

    a_col_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL && r_colc != COL_W'(COLS - 1)) |=>
            (r_state == S_CELL && r_colc == $past(r_colc) + COL_W'(1)))
        else $error("column sweep skipped a cell");

    a_new_word_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result word issued outside the completion state");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !w_we)
        else $error("grid memory written while no item is in progress");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL || r_state == S_WB) |-> (int'(r_rowc) < ROWS))
        else $error("row counter left the grid during an advance");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tlge_pkg::*;

    typedef struct packed {
        logic               alive;
        logic [GEN_W-1:0]   gen;
        logic [COUNT_W-1:0] live;
        logic [COUNT_W-1:0] born;
        logic [COUNT_W-1:0] died;
    } t_status;

    typedef struct {
        t_op              op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             alive;
        bit               typed;
        t_status          status;
    } t_dir_row;

    localparam int GLIDE_R [5]    = '{0, 1, 2, 2, 2};
    localparam int GLIDE_C [5]    = '{1, 2, 0, 1, 2};
    localparam int SEND_IDLE [4]  = '{0, 86, 0, 25};
    localparam int RECV_STALL [4] = '{0, 0, 86, 25};

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic [OP_W-1:0]    i_op      = '0;
    logic [IDX_W-1:0]   i_row     = '0;
    logic [IDX_W-1:0]   i_col     = '0;
    logic               i_cell_in = 1'b0;
    logic               i_stall   = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_cell_out;
    logic [GEN_W-1:0]   o_generation;
    logic [COUNT_W-1:0] o_live_count;
    logic [COUNT_W-1:0] o_born_count;
    logic [COUNT_W-1:0] o_died_count;

    logic [COLS-1:0]    life_grid [ROWS];
    logic [GEN_W-1:0]   gen_tally  = '0;
    logic [COUNT_W-1:0] live_tally = '0;
    logic [COUNT_W-1:0] born_tally = '0;
    logic [COUNT_W-1:0] died_tally = '0;

    t_status  due_words [$];
    t_dir_row dir_rows [$];
    int       words_sent    = 0;
    int       err_cnt       = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;

    toroidal_life_grid_engine uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_in    (i_cell_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_out   (o_cell_out),
        .o_generation (o_generation),
        .o_live_count (o_live_count),
        .o_born_count (o_born_count),
        .o_died_count (o_died_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [COUNT_W-1:0] clip_count(input int n);
        return (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
    endfunction

    task automatic step_generation();
        logic [COLS-1:0] nxt [ROWS];
        int sum, live, born, died;
        logic was, now;
        live = 0;
        born = 0;
        died = 0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                sum = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        sum += life_grid[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS];
                    end
                end
                was = life_grid[r][c];
                now = was ? (sum == BIRTH_SUM || sum == KEEP_SUM) : (sum == BIRTH_SUM);
                nxt[r][c] = now;
                live += now;
                born += (now && !was);
                died += (!now && was);
            end
        end
        life_grid  = nxt;
        live_tally = clip_count(live);
        born_tally = clip_count(born);
        died_tally = clip_count(died);
        gen_tally  = gen_tally + 1'b1;
    endtask

    task automatic life_apply(input t_op op, input logic [IDX_W-1:0] row, col,
                              input logic alive, output t_status res);
        bit in_grid;
        in_grid = (row < ROWS) && (col < COLS);
        res = '0;
        case (op)
            OP_ADVANCE: step_generation();
            OP_WRITE: if (in_grid) life_grid[row][col] = alive;
            OP_CLEAR: foreach (life_grid[r]) life_grid[r] = '0;
            OP_READ: if (in_grid) res.alive = life_grid[row][col];
            default: ;
        endcase
        res.gen  = gen_tally;
        res.live = live_tally;
        res.born = born_tally;
        res.died = died_tally;
    endtask

    task automatic send_word(input t_op op, input logic [IDX_W-1:0] row, col,
                             input logic alive, input bit typed = 1'b0,
                             input t_status typed_res = '0);
        t_status pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_row     <= row;
        i_col     <= col;
        i_cell_in <= alive;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        life_apply(op, row, col, alive, pred);
        due_words = {due_words, (typed ? typed_res : pred)};
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic add_dir(input t_op op, input int row, col, input logic alive,
                           input bit typed = 1'b0, input t_status status = '0);
        t_dir_row d;
        d.op     = op;
        d.row    = IDX_W'(row);
        d.col    = IDX_W'(col);
        d.alive  = alive;
        d.typed  = typed;
        d.status = status;
        dir_rows = {dir_rows, d};
    endtask

    // A short life: an optional clear, a glider or a small random soup written around
    // a random corner (so that it can straddle the wrap), one or two steps, then
    // reads around the same spot, with the odd unrelated word mixed in.
    task automatic run_episode();
        logic [IDX_W-1:0] br, bc;
        bit glider;
        int n;
        br = IDX_W'($urandom);
        bc = IDX_W'($urandom);
        if ($urandom_range(2) == 0) begin
            send_word(OP_CLEAR, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom));
        end
        glider = ($urandom_range(2) == 0);
        n = glider ? 5 : $urandom_range(3, 12);
        for (int k = 0; k < n; k++) begin
            if (glider) begin
                send_word(OP_WRITE, IDX_W'(br + GLIDE_R[k]), IDX_W'(bc + GLIDE_C[k]), 1'b1);
            end else begin
                send_word(OP_WRITE, IDX_W'(br + $urandom_range(4)),
                          IDX_W'(bc + $urandom_range(4)), $urandom_range(7) != 0);
            end
        end
        repeat ($urandom_range(1, 2)) begin
            send_word(OP_ADVANCE, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom));
        end
        repeat ($urandom_range(2, 4)) begin
            send_word(OP_READ, IDX_W'(br + $urandom_range(6) - 1),
                      IDX_W'(bc + $urandom_range(6) - 1), 1'($urandom));
        end
        if ($urandom_range(3) == 0) begin
            send_word(t_op'($urandom_range(3)), IDX_W'($urandom), IDX_W'($urandom),
                      1'($urandom));
        end
    endtask

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < stall_pct);

    task automatic check_field(input string what, input logic [GEN_W-1:0] want, got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_status got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_cell_out, o_generation, o_live_count, o_born_count, o_died_count};
            if (due_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                err_cnt++;
            end else begin
                want = due_words.pop_front();
                check_field("cell_out", GEN_W'(want.alive), GEN_W'(got.alive));
                check_field("generation", want.gen, got.gen);
                check_field("live_count", GEN_W'(want.live), GEN_W'(got.live));
                check_field("born_count", GEN_W'(want.born), GEN_W'(got.born));
                check_field("died_count", GEN_W'(want.died), GEN_W'(got.died));
            end
        end
    end

    initial begin
        foreach (life_grid[r]) life_grid[r] = '0;

        add_dir(OP_READ, 0, 0, 1'b1, 1'b1, t_status'{1'b0, 32'd0, 13'd0, 13'd0, 13'd0});
        add_dir(OP_READ, 63, 63, 1'b0, 1'b1, t_status'{1'b0, 32'd0, 13'd0, 13'd0, 13'd0});
        add_dir(OP_ADVANCE, 63, 0, 1'b1, 1'b1, t_status'{1'b0, 32'd1, 13'd0, 13'd0, 13'd0});
        add_dir(OP_WRITE, 0, 0, 1'b1);
        add_dir(OP_READ, 0, 0, 1'b0);
        add_dir(OP_WRITE, 0, 0, 1'b0);
        add_dir(OP_READ, 0, 0, 1'b1);
        // Two blinkers, one across the column wrap and one across the row wrap.
        add_dir(OP_WRITE, 5, 63, 1'b1);
        add_dir(OP_WRITE, 5, 0, 1'b1);
        add_dir(OP_WRITE, 5, 1, 1'b1);
        add_dir(OP_WRITE, 63, 10, 1'b1);
        add_dir(OP_WRITE, 0, 10, 1'b1);
        add_dir(OP_WRITE, 1, 10, 1'b1);
        add_dir(OP_ADVANCE, 0, 63, 1'b0);
        add_dir(OP_READ, 4, 0, 1'b0);
        add_dir(OP_READ, 5, 63, 1'b1);
        add_dir(OP_READ, 0, 9, 1'b0);
        add_dir(OP_READ, 63, 10, 1'b0);
        add_dir(OP_CLEAR, 63, 63, 1'b1);
        add_dir(OP_READ, 4, 0, 1'b0);
        add_dir(OP_ADVANCE, 0, 0, 1'b0, 1'b1, t_status'{1'b0, 32'd3, 13'd0, 13'd0, 13'd0});
        add_dir(OP_WRITE, 63, 63, 1'b1);
        add_dir(OP_ADVANCE, 0, 0, 1'b1, 1'b1, t_status'{1'b0, 32'd4, 13'd0, 13'd0, 13'd1});

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].op, dir_rows[i].row, dir_rows[i].col, dir_rows[i].alive,
                      dir_rows[i].typed, dir_rows[i].status);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            stall_pct     = RECV_STALL[ph];
            while (words_sent < dir_rows.size() + 28 * (ph + 1)) run_episode();
        end
        i_valid <= 1'b0;

        while (due_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
